/* design/tlvp_pkg.sv */
package tlvp_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_CHECK  = 2'd2
   } phase_type;

   // result kind, travels on rsp_tuser
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

   // configuration register indexes
   localparam logic CSR_MAX_LENGTH    = 1'b0;
   localparam logic CSR_CAPTURE_LIMIT = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   localparam logic [15:0] MAX_LENGTH_RESET    = 16'd1024;
   localparam logic [15:0] CAPTURE_LIMIT_RESET = 16'hFFFF;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
   } result_type;

endpackage

/* design/tlvp_parser.sv */
module tlvp_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tlvp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tlvp_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               byte_accept,
   input  logic [7:0]                         rx_byte,
   output logic                               res_valid,
   output tlvp_pkg::result_type               res
);
   import tlvp_pkg::*;

   logic [15:0] max_length_ff, capture_limit_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  frame_tag_ff, frame_tag_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] payload_length_ff, payload_length_in;
   logic [15:0] body_count_ff, body_count_in;
   logic [7:0]  running_xor_ff, running_xor_in;

   logic        capture;
   logic [15:0] check_count;
   logic [7:0]  expect_byte;

   assign capture     = body_count_ff < capture_limit_ff;
   assign check_count = capture ? body_count_ff : capture_limit_ff;
   assign expect_byte = frame_tag_ff ^ check_count[15:8] ^ check_count[7:0] ^ running_xor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff    <= MAX_LENGTH_RESET;
         capture_limit_ff <= CAPTURE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_LENGTH:    max_length_ff    <= csr_data;
            CSR_CAPTURE_LIMIT: capture_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HEADER;
         header_count_ff   <= 2'd0;
         frame_tag_ff      <= 8'd0;
         length_high_ff    <= 8'd0;
         payload_length_ff <= 16'd0;
         body_count_ff     <= 16'd0;
         running_xor_ff    <= 8'd0;
      end else begin
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         frame_tag_ff      <= frame_tag_in;
         length_high_ff    <= length_high_in;
         payload_length_ff <= payload_length_in;
         body_count_ff     <= body_count_in;
         running_xor_ff    <= running_xor_in;
      end
   end

   // next state
   always_comb begin
      phase_in          = phase_ff;
      header_count_in   = header_count_ff;
      frame_tag_in      = frame_tag_ff;
      length_high_in    = length_high_ff;
      payload_length_in = payload_length_ff;
      body_count_in     = body_count_ff;
      running_xor_in    = running_xor_ff;
      if (byte_accept) begin
         case (phase_ff)
            PH_BODY: begin
               body_count_in = body_count_ff + 16'd1;
               if (capture) running_xor_in = running_xor_ff ^ rx_byte;
               if (body_count_in >= payload_length_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in        = PH_HEADER;
               header_count_in = 2'd0;
            end
            default: begin
               case (header_count_ff)
                  2'd0: begin
                     frame_tag_in    = rx_byte;
                     header_count_in = 2'd1;
                  end
                  2'd1: begin
                     length_high_in  = rx_byte;
                     header_count_in = 2'd2;
                  end
                  default: begin
                     payload_length_in = {length_high_ff, rx_byte};
                     header_count_in   = 2'd0;
                     if (payload_length_in > max_length_ff) begin
                        // oversized, drop header and hunt again
                        phase_in = PH_HEADER;
                     end else begin
                        body_count_in  = 16'd0;
                        running_xor_in = 8'd0;
                        phase_in = (payload_length_in == 16'd0) ? PH_CHECK : PH_BODY;
                     end
                  end
               endcase
            end
         endcase
      end
   end

   // result
   always_comb begin
      res_valid         = 1'b0;
      res.kind          = KIND_PAYLOAD;
      res.data_byte     = rx_byte;
      res.payload_index = body_count_ff;
      res.frame_length  = 16'd0;
      case (phase_ff)
         PH_BODY: begin
            res_valid = byte_accept && capture;
         end
         PH_CHECK: begin
            res_valid         = byte_accept;
            res.kind          = (rx_byte == expect_byte) ? KIND_GOOD : KIND_BAD;
            res.data_byte     = frame_tag_ff;
            res.payload_index = 16'd0;
            res.frame_length  = payload_length_ff;
         end
         default: ;
      endcase
   end

endmodule

/* design/tlvp_out_reg.sv */
module tlvp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tlvp_pkg::result_type  res,
   input  logic                  out_ready,
   output logic                  space,
   output logic                  out_valid,
   output tlvp_pkg::result_type  out_res
);
   import tlvp_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign space     = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

endmodule

/* design/tlv_frame_parser_top.sv */
// tlv frame parser, one received byte per request
// frames are: tag byte, 16-bit big-endian length, payload bytes, xor checksum byte
// req channel carries the received byte in req_tdata
// rsp channel carries one result: a captured payload byte (kind payload) or an
// end-of-frame report (kind good or bad) with the tag and declared length
// results are produced only for captured payload bytes and checksum bytes;
// header bytes and payload bytes past the capture limit give nothing
// a result is registered and is on rsp in the cycle after its request is accepted
// throughput: one request per cycle while rsp is not stalled, set by the state update of
// the parser and the one-deep result register
// when rsp stalls with a result held, req_tready drops until it is taken
// csr port: index 0 max accepted length, index 1 capture limit, written at once
// reset clears the parser to the header hunt, empties the result register and
// loads the register defaults (max length 1024, capture limit 65535)
module tlv_frame_parser_top (
   input  logic                               clock,
   input  logic                               reset,
   // request: [7:0] rx_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // result data: [7:0] data_byte, [23:8] payload_index, [39:24] frame_length
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tlvp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // result user: [1:0] kind
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [tlvp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tlvp_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tlvp_pkg::*;

   logic       space;
   logic       byte_accept;
   logic       res_valid;
   result_type res;
   result_type out_res;

   assign req_tready  = space;
   assign byte_accept = req_tvalid && space;

   // parser state and per-byte result logic
   tlvp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .res_valid   (res_valid),
      .res         (res)
   );

   // result register decouples the two sides
   tlvp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .out_ready (rsp_tready),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_res   (out_res)
   );

   assign rsp_tdata = {out_res.frame_length, out_res.payload_index, out_res.data_byte};
   assign rsp_tuser = out_res.kind;

endmodule
